// ===== hdl/pspt_pkg.sv =====
`default_nettype none
package pspt_pkg;
	localparam int DEPTH_DEF = 256;
	localparam int COORD_BITS_DEF = 16;
	localparam int DIST_BITS = 17;
	localparam int TOTAL_BITS = 9;
	localparam logic [DIST_BITS-1:0] DIST_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_DIST   = 3'd1,
		FN_ELIM   = 3'd2,
		FN_POPF   = 3'd3,
		FN_POPL   = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_RANGE = 3'd2,
		ST_EMPTY = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef struct packed {
		logic start;
		logic [63:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] root;
	} sqrt_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/pspt_if.sv =====
`default_nettype none
interface pspt_in_if;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic [7:0] index_first;
	logic [7:0] index_second;
	logic [16:0] radius;
	modport source(output valid, func, point_x, point_y, index_first, index_second, radius,
		input ready);
	modport sink(input valid, func, point_x, point_y, index_first, index_second, radius,
		output ready);
endinterface

interface pspt_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [16:0] distance;
	logic [8:0] entry_total;
	modport source(output valid, status, distance, entry_total, input ready);
	modport sink(input valid, status, distance, entry_total, output ready);
endinterface
`default_nettype wire

// ===== hdl/pspt_ram.sv =====
`default_nettype none
module pspt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/pspt_sqrt.sv =====
`default_nettype none
module pspt_sqrt
	import pspt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sqrt_req_t req,
	output sqrt_rsp_t      rsp
);
	// Restoring square root, one result bit per cycle.
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [65:0] acc_q;
	logic        busy_q;
	logic        done_q;
	logic [65:0] acc_n;
	logic [65:0] trial;

	always_comb begin
		acc_n = {acc_q[63:0], rem_q[63:62]};
		trial = 66'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
				rem_q  <= req.radicand;
				acc_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q <= {rem_q[61:0], 2'b00};
				if (acc_n >= trial) begin
					acc_q  <= acc_n - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					acc_q  <= acc_n;
					root_q <= {root_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule
`default_nettype wire

// ===== hdl/point_set_proximity_table_core.sv =====
// Insert and eliminate walk the stored entries, remove first shifts the store, distance
// reads both entries and then waits on the square-root unit, and the other functions go
// straight to the result state. One item at a time; the entry sweep through the point
// memory, or the square root for a distance, sets the rate, and a result still waiting in
// the output register holds the next one in its last state.
// Reset clears the fill count and control state; point memory is not cleared.
`default_nettype none
module point_set_proximity_table_core
	import pspt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pspt_in_if.sink  in_ch,
	pspt_out_if.source out_ch
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = 2 * COORD_BITS;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_REF   = 8'b0000_0100,
		S_ELIM  = 8'b0000_1000,
		S_SHIFT = 8'b0001_0000,
		S_DIST  = 8'b0010_0000,
		S_SQRT  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CW-1:0] fill_q, rd_q, wr_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, rx_q, ry_q;
	logic [7:0]  i_q, j_q;
	logic [16:0] rad_q;
	logic        dup_q, pend_s1, phase_q;
	logic [2:0]  status_q;
	logic [16:0] dist_q;
	logic        oval_q;
	logic [2:0]  ostat_q;
	logic [16:0] odist_q;
	logic [TOTAL_BITS-1:0] ototal_q;
	logic        out_load;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [PW-1:0] wdata, rdata;
	sqrt_req_t sreq;
	sqrt_rsp_t srsp;

	pspt_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	pspt_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	logic signed [COORD_BITS-1:0] ex, ey;
	logic signed [COORD_BITS:0] ddx, ddy;
	logic [COORD_BITS:0] adx, ady;
	logic [2*COORD_BITS+2:0] d2;
	logic [35:0] r2;
	logic near;
	assign ex = rdata[PW-1:COORD_BITS];
	assign ey = rdata[COORD_BITS-1:0];
	always_comb begin
		ddx = {ex[COORD_BITS-1], ex} - {rx_q[COORD_BITS-1], rx_q};
		ddy = {ey[COORD_BITS-1], ey} - {ry_q[COORD_BITS-1], ry_q};
		adx = ddx[COORD_BITS] ? (COORD_BITS+1)'(-ddx) : ddx;
		ady = ddy[COORD_BITS] ? (COORD_BITS+1)'(-ddy) : ddy;
		d2  = (2*COORD_BITS+3)'(adx * adx) + (2*COORD_BITS+3)'(ady * ady);
		r2  = 36'(rad_q) * 36'(rad_q);
		near = (64'(d2) <= 64'(r2));
	end

	logic [AW-1:0] rd_a;
	assign rd_a = rd_q[AW-1:0];
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!oval_q || out_ch.ready);

	always_comb begin
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		raddr = rd_a;
		sreq.start = 1'b0;
		sreq.radicand = 64'(d2);
		unique case (state_q)
			S_SCAN: if (rd_q == fill_q && !pend_s1 && !dup_q && fill_q < CW'(DEPTH)) begin
				we = 1'b1;
				waddr = fill_q[AW-1:0];
				wdata = {px_q, py_q};
			end
			S_ELIM, S_SHIFT: begin
				if (pend_s1 && (state_q == S_SHIFT || !(CW'(i_q) != rd_q - CW'(1)) || !near))
					we = 1'b1;
			end
			S_DIST: if (!phase_q && pend_s1) sreq.start = 1'b1;
			S_IDLE: raddr = AW'(in_ch.index_first);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pend_s1 <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			phase_q <= 1'b0;
			dup_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					px_q <= COORD_BITS'(in_ch.point_x);
					py_q <= COORD_BITS'(in_ch.point_y);
					i_q <= in_ch.index_first;
					j_q <= in_ch.index_second;
					rad_q <= in_ch.radius;
					status_q <= ST_OK;
					dist_q <= '0;
					dup_q <= 1'b0;
					pend_s1 <= 1'b0;
					unique case (in_ch.func)
						FN_INSERT: begin
							rd_q <= '0;
							state_q <= S_SCAN;
						end
						FN_DIST: begin
							if (CW'(in_ch.index_first) >= fill_q ||
							    CW'(in_ch.index_second) >= fill_q) begin
								status_q <= ST_RANGE;
								state_q <= S_OUT;
							end else if (in_ch.index_first == in_ch.index_second) begin
								state_q <= S_OUT;
							end else begin
								phase_q <= 1'b0;
								state_q <= S_DIST;
							end
						end
						FN_ELIM: begin
							if (CW'(in_ch.index_first) >= fill_q) begin
								status_q <= ST_RANGE;
								state_q <= S_OUT;
							end else state_q <= S_REF;
						end
						FN_POPF: begin
							if (fill_q == '0) begin
								status_q <= ST_EMPTY;
								state_q <= S_OUT;
							end else begin
								rd_q <= CW'(1);
								wr_q <= '0;
								state_q <= S_SHIFT;
							end
						end
						FN_POPL: begin
							if (fill_q == '0) status_q <= ST_EMPTY;
							else fill_q <= fill_q - CW'(1);
							state_q <= S_OUT;
						end
						FN_CLEAR: begin
							fill_q <= '0;
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_SCAN: begin
					if (pend_s1 && ex == px_q && ey == py_q) dup_q <= 1'b1;
					if (rd_q < fill_q) begin
						pend_s1 <= 1'b1;
						rd_q <= rd_q + CW'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						if (dup_q) status_q <= ST_DUP;
						else if (fill_q >= CW'(DEPTH)) status_q <= ST_FULL;
						else fill_q <= fill_q + CW'(1);
						state_q <= S_OUT;
					end
				end
				S_REF: begin
					rx_q <= ex;
					ry_q <= ey;
					rd_q <= CW'(1);
					wr_q <= CW'(1);
					state_q <= S_ELIM;
				end
				S_ELIM, S_SHIFT: begin
					if (we) wr_q <= wr_q + CW'(1);
					if (rd_q < fill_q) begin
						pend_s1 <= 1'b1;
						rd_q <= rd_q + CW'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						fill_q <= wr_q;
						state_q <= S_OUT;
					end
				end
				S_DIST: begin
					// Entry j is read first and held as the reference, then entry i
					// arrives and the square root starts on the last cycle.
					if (!phase_q && !pend_s1) begin
						rd_q <= CW'(j_q);
						phase_q <= 1'b1;
					end else if (phase_q && !pend_s1) begin
						rd_q <= CW'(i_q);
						pend_s1 <= 1'b1;
					end else if (phase_q) begin
						rx_q <= ex;
						ry_q <= ey;
						phase_q <= 1'b0;
					end else state_q <= S_SQRT;
				end
				S_SQRT: if (srsp.done) begin
					dist_q <= (srsp.root > 32'(DIST_MAX)) ? DIST_MAX : srsp.root[16:0];
					state_q <= S_OUT;
				end
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The result register lets the next item start while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			ostat_q <= '0;
			odist_q <= '0;
			ototal_q <= '0;
		end else if (out_load) begin
			oval_q <= 1'b1;
			ostat_q <= status_q;
			odist_q <= dist_q;
			ototal_q <= TOTAL_BITS'(fill_q);
		end else if (out_ch.ready) begin
			oval_q <= 1'b0;
		end
	end

	assign out_ch.valid = oval_q;
	assign out_ch.status = ostat_q;
	assign out_ch.distance = odist_q;
	assign out_ch.entry_total = ototal_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH)) else $error("fill count beyond depth");
	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ELIM || state_q == S_SHIFT) |-> wr_q <= rd_q)
		else $error("compaction write passed read");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !out_ch.ready) |=> oval_q) else $error("result dropped");
endmodule
`default_nettype wire
